@@ rtl/seot_pkg.sv @@
package seot_pkg;

    localparam int NUM_OBJECTS = 16;
    localparam int NUM_TASKS   = 64;
    localparam int EVENT_BITS  = 16;
    localparam int OBJ_W       = $clog2(NUM_OBJECTS);
    localparam int TASK_W      = $clog2(NUM_TASKS);
    localparam int PROBE_W     = $clog2(NUM_OBJECTS + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;

    localparam logic [EVENT_BITS-1:0] COUNT_MAX = {EVENT_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_CREATE  = 2'd0,
        KIND_SIGNAL  = 2'd1,
        KIND_DESTROY = 2'd2,
        KIND_WAIT    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Request word handed from the front to the back.
    typedef struct packed {
        kind_t             kind;
        logic [3:0]        handle;
        logic [TASK_W-1:0] task_id;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROBE,
        BK_LINK,
        BK_OUT
    } bk_state_t;

endpackage

@@ rtl/sync_event_object_table_top.sv @@
// Synchronization object table: 16 slots, each with a valid mark, a
// saturating 16-bit event count and a FIFO of waiting task ids.
// Input channel (in_valid/in_ready): one request word of kind, handle and
// task_id. Output channel (out_valid/out_ready): one result word per request.
// A two-word queue parts the front from the back, so the front takes words
// while the back is busy or its result waits to be taken.
// Signal, destroy and wait pass the sequencer steps take, link read and
// result; create probes the slots one by one in place of the link read. The
// back takes no new word until its result is taken, and its three sequencer
// steps (take, link, result) set the pace for non-create requests.
// Reset empties the queue and frees all slots. When the receiver stalls the
// result holds and up to two more words are queued, then in_ready drops.
module sync_event_object_table_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [3:0] handle,
    input  logic [5:0] task_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [3:0] new_handle,
    output logic       wake_valid,
    output logic [5:0] wake_task,
    output logic       proceed,
    output logic       blocked
);

    seot_pkg::req_t in_req, q_req;
    logic           q_valid, q_ready;

    assign in_req.kind    = seot_pkg::kind_t'(kind);
    assign in_req.handle  = handle;
    assign in_req.task_id = task_id[seot_pkg::TASK_W-1:0];

    seot_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    seot_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .new_handle (new_handle),
        .wake_valid (wake_valid),
        .wake_task  (wake_task),
        .proceed    (proceed),
        .blocked    (blocked)
    );

endmodule

@@ rtl/seot_ram.sv @@
module seot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/seot_front.sv @@
module seot_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  seot_pkg::req_t           in_req,
    output logic                     q_valid,
    input  logic                     q_ready,
    output seot_pkg::req_t           q_req
);

    seot_pkg::req_t                  buf_reg [seot_pkg::QDEPTH];
    logic [seot_pkg::QPTR_W-1:0]     wr_reg, rd_reg;
    logic [seot_pkg::QPTR_W:0]       cnt_reg;
    logic                            push, pop;

    assign in_ready = (cnt_reg != seot_pkg::QPTR_W'(0) + (seot_pkg::QPTR_W+1)'(seot_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Words are stored with the task id already reduced to the table size.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_req;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (seot_pkg::QPTR_W+1)'(push) - (seot_pkg::QPTR_W+1)'(pop);
        end
    end

`ifndef SYNTH
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (seot_pkg::QPTR_W+1)'(seot_pkg::QDEPTH))
        else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("fill count wrong");
`endif

endmodule

@@ rtl/seot_back.sv @@
module seot_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  seot_pkg::req_t                q_req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [3:0]                    new_handle,
    output logic                          wake_valid,
    output logic [5:0]                    wake_task,
    output logic                          proceed,
    output logic                          blocked
);

    localparam int OW = seot_pkg::OBJ_W;
    localparam int TW = seot_pkg::TASK_W;
    localparam int EW = seot_pkg::EVENT_BITS;

    seot_pkg::bk_state_t       state_reg, state_next;
    seot_pkg::req_t            req_reg, req_next;
    logic [OW-1:0]             probe_reg, probe_next;
    logic [seot_pkg::PROBE_W-1:0] tries_reg, tries_next;

    logic [seot_pkg::NUM_OBJECTS-1:0] in_use_reg, in_use_next;
    logic [seot_pkg::NUM_OBJECTS-1:0] nonempty_reg, nonempty_next;
    logic [EW-1:0]             count_reg [seot_pkg::NUM_OBJECTS];
    logic [EW-1:0]             count_next [seot_pkg::NUM_OBJECTS];
    logic [TW-1:0]             head_reg [seot_pkg::NUM_OBJECTS];
    logic [TW-1:0]             head_next [seot_pkg::NUM_OBJECTS];
    logic [TW-1:0]             tail_reg [seot_pkg::NUM_OBJECTS];
    logic [TW-1:0]             tail_next [seot_pkg::NUM_OBJECTS];

    logic [1:0]                status_reg, status_next;
    logic [3:0]                newh_reg, newh_next;
    logic                      wv_reg, wv_next;
    logic [5:0]                wt_reg, wt_next;
    logic                      pr_reg, pr_next;
    logic                      bl_reg, bl_next;

    // Link memory: next waiter of each task.
    logic                      lk_we;
    logic [TW-1:0]             lk_waddr, lk_wdata, lk_raddr, lk_rdata;

    logic [OW-1:0]             slot;
    logic                      slot_ok;

    seot_ram #(.WIDTH(TW), .DEPTH(seot_pkg::NUM_TASKS)) u_link (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    assign slot    = req_reg.handle[OW-1:0];
    assign slot_ok = in_use_reg[slot];
    assign q_ready = (state_reg == seot_pkg::BK_IDLE);
    assign out_valid  = (state_reg == seot_pkg::BK_OUT);
    assign status     = status_reg;
    assign new_handle = newh_reg;
    assign wake_valid = wv_reg;
    assign wake_task  = wt_reg;
    assign proceed    = pr_reg;
    assign blocked    = bl_reg;

    // Link read address: while idle, the head of the queue addressed by the
    // incoming word, so that its link is ready in the following cycle.
    assign lk_raddr = (state_reg == seot_pkg::BK_IDLE) ? head_reg[q_req.handle[OW-1:0]]
                      : head_reg[slot];

    // Control and table state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= seot_pkg::BK_IDLE;
            in_use_reg   <= '0;
            nonempty_reg <= '0;
            for (int i = 0; i < seot_pkg::NUM_OBJECTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        probe_reg  <= probe_next;
        tries_reg  <= tries_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        status_reg <= status_next;
        newh_reg   <= newh_next;
        wv_reg     <= wv_next;
        wt_reg     <= wt_next;
        pr_reg     <= pr_next;
        bl_reg     <= bl_next;
    end

    // Sequencer: take a word, probe or read the link, then present the result.
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        probe_next    = probe_reg;
        tries_next    = tries_reg;
        in_use_next   = in_use_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        status_next   = status_reg;
        newh_next     = newh_reg;
        wv_next       = wv_reg;
        wt_next       = wt_reg;
        pr_next       = pr_reg;
        bl_next       = bl_reg;
        lk_we         = 1'b0;
        lk_waddr      = tail_reg[slot];
        lk_wdata      = req_reg.task_id;
        case (state_reg)
            seot_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    req_next    = q_req;
                    probe_next  = q_req.handle[OW-1:0];
                    tries_next  = '0;
                    status_next = seot_pkg::ST_OK;
                    newh_next   = '0;
                    wv_next     = 1'b0;
                    wt_next     = '0;
                    pr_next     = 1'b0;
                    bl_next     = 1'b0;
                    if (q_req.kind == seot_pkg::KIND_CREATE)
                    begin
                        state_next = seot_pkg::BK_PROBE;
                    end
                    else
                    begin
                        state_next = seot_pkg::BK_LINK;
                    end
                end
            end
            seot_pkg::BK_PROBE:
            begin
                // One slot examined per cycle, wrapping upward.
                if (tries_reg == seot_pkg::PROBE_W'(seot_pkg::NUM_OBJECTS))
                begin
                    status_next = seot_pkg::ST_FULL;
                    state_next  = seot_pkg::BK_OUT;
                end
                else if (!in_use_reg[probe_reg])
                begin
                    in_use_next[probe_reg]   = 1'b1;
                    nonempty_next[probe_reg] = 1'b0;
                    count_next[probe_reg]    = '0;
                    newh_next  = 4'(probe_reg);
                    state_next = seot_pkg::BK_OUT;
                end
                else
                begin
                    probe_next = (probe_reg == OW'(seot_pkg::NUM_OBJECTS - 1)) ? '0
                                 : probe_reg + 1'b1;
                    tries_next = tries_reg + 1'b1;
                end
            end
            seot_pkg::BK_LINK:
            begin
                // Link data for the queue head is valid here.
                state_next = seot_pkg::BK_OUT;
                if (!slot_ok)
                begin
                    status_next = seot_pkg::ST_INVALID;
                end
                else
                begin
                    case (req_reg.kind)
                        seot_pkg::KIND_SIGNAL:
                        begin
                            if (nonempty_reg[slot])
                            begin
                                wv_next = 1'b1;
                                wt_next = 6'(head_reg[slot]);
                                if (head_reg[slot] == tail_reg[slot])
                                begin
                                    nonempty_next[slot] = 1'b0;
                                end
                                else
                                begin
                                    head_next[slot] = lk_rdata;
                                end
                            end
                            else if (count_reg[slot] != seot_pkg::COUNT_MAX)
                            begin
                                count_next[slot] = count_reg[slot] + 1'b1;
                            end
                        end
                        seot_pkg::KIND_DESTROY:
                        begin
                            in_use_next[slot]   = 1'b0;
                            nonempty_next[slot] = 1'b0;
                            count_next[slot]    = '0;
                        end
                        seot_pkg::KIND_WAIT:
                        begin
                            if (count_reg[slot] != '0)
                            begin
                                count_next[slot] = count_reg[slot] - 1'b1;
                                pr_next = 1'b1;
                            end
                            else
                            begin
                                if (nonempty_reg[slot])
                                begin
                                    lk_we = 1'b1;
                                end
                                else
                                begin
                                    head_next[slot]     = req_reg.task_id;
                                    nonempty_next[slot] = 1'b1;
                                end
                                tail_next[slot] = req_reg.task_id;
                                bl_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = seot_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            seot_pkg::BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = seot_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = seot_pkg::BK_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_one_of: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pr_reg && bl_reg))
        else $error("proceed and blocked together");
    a_wake_sig: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wv_reg) |-> req_reg.kind == seot_pkg::KIND_SIGNAL)
        else $error("wake from non-signal");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status_reg))
        else $error("result dropped");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> state_reg != seot_pkg::BK_IDLE)
        else $error("word not taken");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // Result word fields as the block reports them.
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] new_handle;
        logic       wake_valid;
        logic [5:0] wake_task;
        logic       proceed;
        logic       blocked;
    } result_t;

    // Object table predictor and store of pending results.
    class obj_table_sb;
        bit                            in_use [seot_pkg::NUM_OBJECTS];
        bit [seot_pkg::EVENT_BITS-1:0] events [seot_pkg::NUM_OBJECTS];
        bit [seot_pkg::TASK_W-1:0]     head [seot_pkg::NUM_OBJECTS];
        bit [seot_pkg::TASK_W-1:0]     tail [seot_pkg::NUM_OBJECTS];
        bit                            nonempty [seot_pkg::NUM_OBJECTS];
        bit [seot_pkg::TASK_W-1:0]     link [seot_pkg::NUM_TASKS];
        result_t                       pending [$];
        int                            mismatches;

        function void note_request(seot_pkg::kind_t k, logic [3:0] h, logic [5:0] t);
            result_t r;
            int s;
            r = '0;
            if (k == seot_pkg::KIND_CREATE)
            begin
                r.status = seot_pkg::ST_FULL;
                for (int i = 0; i < seot_pkg::NUM_OBJECTS; i++)
                begin
                    s = (h + i) % seot_pkg::NUM_OBJECTS;
                    if (!in_use[s])
                    begin
                        in_use[s] = 1;
                        events[s] = 0;
                        nonempty[s] = 0;
                        r.new_handle = 4'(s);
                        r.status = seot_pkg::ST_OK;
                        break;
                    end
                end
            end
            else if (!in_use[h])
                r.status = seot_pkg::ST_INVALID;
            else if (k == seot_pkg::KIND_SIGNAL)
            begin
                if (nonempty[h])
                begin
                    r.wake_valid = 1;
                    r.wake_task = head[h];
                    if (head[h] == tail[h])
                        nonempty[h] = 0;
                    else
                        head[h] = link[head[h]];
                end
                else if (events[h] != seot_pkg::COUNT_MAX)
                    events[h]++;
            end
            else if (k == seot_pkg::KIND_DESTROY)
            begin
                in_use[h] = 0;
                nonempty[h] = 0;
                events[h] = 0;
            end
            else if (events[h] != 0)
            begin
                events[h]--;
                r.proceed = 1;
            end
            else
            begin
                if (nonempty[h])
                    link[tail[h]] = t;
                else
                begin
                    head[h] = t;
                    nonempty[h] = 1;
                end
                tail[h] = t;
                r.blocked = 1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [3:0] handle;
    logic [5:0] task_id;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [3:0] new_handle;
    logic       wake_valid;
    logic [5:0] wake_task;
    logic       proceed;
    logic       blocked;

    obj_table_sb tbl;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          quiet_cycles;
    bit          bad;
    bit          task_busy [seot_pkg::NUM_TASKS];
    int          task_obj [seot_pkg::NUM_TASKS];

    sync_event_object_table_top dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Send one request word and hold it until accepted. Valid stays high
    // into the next word unless the sender idles.
    task automatic send_word(seot_pkg::kind_t k, logic [3:0] h, logic [5:0] t);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        handle <= h;
        task_id <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tbl.note_request(k, h, t);
        if (k == seot_pkg::KIND_WAIT && tbl.pending[$].blocked)
        begin
            task_busy[t] = 1;
            task_obj[t] = h;
        end
        if (k == seot_pkg::KIND_SIGNAL && tbl.pending[$].wake_valid)
            task_busy[tbl.pending[$].wake_task] = 0;
        if (k == seot_pkg::KIND_DESTROY)
            for (int i = 0; i < seot_pkg::NUM_TASKS; i++)
                if (task_busy[i] && task_obj[i] == h)
                    task_busy[i] = 0;
    endtask

    // Random request biased toward slots 0 to 5 and idle tasks.
    task automatic send_random();
        seot_pkg::kind_t k;
        logic [5:0] t;
        int tries;
        k = seot_pkg::kind_t'($urandom_range(3));
        if ($urandom_range(9) == 0)
            k = seot_pkg::KIND_DESTROY;
        tries = 0;
        t = 6'($urandom_range(63));
        while (task_busy[t] && tries < 64)
        begin
            t = 6'($urandom_range(63));
            tries++;
        end
        if (k == seot_pkg::KIND_WAIT && task_busy[t])
            k = seot_pkg::KIND_SIGNAL;
        send_word(k, ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                  : 4'($urandom_range(5)), t);
    endtask

    // Receiver side: random stalls, plus a long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each accepted result word.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tbl.check_result({status, new_handle, wake_valid, wake_task, proceed, blocked});
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        tbl = new();
        rst_n = 0;
        in_valid = 0;
        kind = 0;
        handle = 0;
        task_id = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: invalid slots, full table, saturation-free basics, queueing.
        send_word(seot_pkg::KIND_SIGNAL, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_WAIT, 4'd0, 6'd63);
        send_word(seot_pkg::KIND_DESTROY, 4'd3, 6'd0);
        for (int i = 0; i < 17; i++)
            send_word(seot_pkg::KIND_CREATE, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_WAIT, 4'd15, 6'd63);
        send_word(seot_pkg::KIND_WAIT, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_SIGNAL, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_SIGNAL, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_SIGNAL, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_WAIT, 4'd15, 6'd21);
        send_word(seot_pkg::KIND_DESTROY, 4'd15, 6'd0);
        send_word(seot_pkg::KIND_CREATE, 4'd0, 6'd0);

        // Long receiver hold-off while requests keep coming.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            repeat (12) send_random();
        join

        // Three phases of random traffic with different idle rates.
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 6 : (p == 1) ? 80 : 0;
            recv_idle_pct = (p == 0) ? 80 : (p == 1) ? 6 : 0;
            repeat (560) send_random();
        end
        in_valid <= 0;

        // Drain and settle.
        while (tbl.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        bad = tbl.mismatches != 0;
        if (!bad)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
